/* sv/sbsh_pkg.sv */
`timescale 1ns / 1ps

package sbsh_pkg;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINAL  = 1'b1;

    localparam logic [60:0] MAX_OCTETS = '1;
    localparam logic [7:0]  PAD_BYTE   = 8'h80;
    localparam logic [5:0]  LAST_FILL  = 6'd63;
    localparam logic [5:0]  PRE_LEN_FILL = 6'd55;
    localparam logic [2:0]  LAST_WORD  = 3'd7;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        length_error;
        logic        last;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_ABSORB,
        CMD_FIN,
        CMD_FIN_ERR
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  data;
        logic [63:0] bit_len;
    } t_cmd;

    function automatic logic [31:0] h_init(input logic [2:0] i);
        logic [31:0] r;
        case (i)
            3'd0:    r = 32'h6a09e667;
            3'd1:    r = 32'hbb67ae85;
            3'd2:    r = 32'h3c6ef372;
            3'd3:    r = 32'ha54ff53a;
            3'd4:    r = 32'h510e527f;
            3'd5:    r = 32'h9b05688c;
            3'd6:    r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] k_round(input logic [5:0] t);
        logic [31:0] r;
        case (t)
            6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
            6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
            6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
            6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
            6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
            6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7;
            default: r = 32'hc67178f2;
        endcase
        return r;
    endfunction

endpackage

/* sv/sha256_byte_stream_hasher.sv */
`timescale 1ns / 1ps
// channel   direction  handshake                     payload
// input     in         i_in_valid / o_in_stall       t_in_item: operation, data_byte
// output    out        o_out_valid / i_out_stall     t_out_item: digest_word, word_index,
//                                                    length_error, last
// an absorb beat is taken in ST_IDLE; the 64th byte of a block then runs the compression
// (schedule load, 64 rounds of the single round unit, chain add); overflow: 1 error beat
// a finalize pads one or two blocks a byte a cycle between compressions, then gives 8 beats
// reset is synchronous, active low; no memory clearing pass is needed
// a command queue sits between input and core, so the input stalls only when it fills

module sha256_byte_stream_hasher #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sbsh_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sbsh_pkg::t_out_item o_out
);
    import sbsh_pkg::*;

    logic push, full, pop, empty;
    t_cmd push_cmd, pop_cmd;

    sbsh_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_push     (push),
        .o_cmd      (push_cmd),
        .i_full     (full)
    );

    sbsh_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (pop_cmd),
        .o_empty (empty)
    );

    sbsh_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!empty),
        .o_cmd_pop   (pop),
        .i_cmd       (pop_cmd),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

/* sv/sbsh_front.sv */
`timescale 1ns / 1ps

module sbsh_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  sbsh_pkg::t_in_item i_in,
    output logic              o_push,
    output sbsh_pkg::t_cmd    o_cmd,
    input  logic              i_full
);
    import sbsh_pkg::*;

    logic [60:0] r_count, n_count;
    logic        r_ovf, n_ovf;
    logic        accept;

    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;

    always_comb begin
        n_count       = r_count;
        n_ovf         = r_ovf;
        o_push        = 1'b0;
        o_cmd.kind    = CMD_ABSORB;
        o_cmd.data    = i_in.data_byte;
        o_cmd.bit_len = {r_count, 3'b000};
        if (accept) begin
            if (i_in.operation == OP_FINAL) begin
                o_push     = 1'b1;
                o_cmd.kind = r_ovf ? CMD_FIN_ERR : CMD_FIN;
                n_count    = '0;
                n_ovf      = 1'b0;
            end else if (!r_ovf) begin
                if (r_count == MAX_OCTETS) begin
                    // octet that would overflow the length is dropped
                    n_ovf = 1'b1;
                end else begin
                    o_push  = 1'b1;
                    n_count = r_count + 61'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

endmodule

/* sv/sbsh_fifo.sv */
`timescale 1ns / 1ps

module sbsh_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sbsh_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output sbsh_pkg::t_cmd o_data,
    output logic           o_empty
);
    import sbsh_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

/* sv/sbsh_core.sv */
`timescale 1ns / 1ps

module sbsh_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    output logic                o_cmd_pop,
    input  sbsh_pkg::t_cmd      i_cmd,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sbsh_pkg::t_out_item o_out
);
    import sbsh_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_state;

    t_state      r_state, r_ret;
    logic [5:0]  r_fill;
    logic [511:0] r_buf;
    logic [63:0] r_len;
    logic        r_err;
    logic [31:0] r_win [16];
    logic [31:0] r_v [8];
    logic [31:0] r_chain [8];
    logic [5:0]  r_round;
    logic [2:0]  r_idx;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [31:0] s0, s1, bs0, bs1, ch, maj, t1, t2, w_new;
    logic        out_free, out_last;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    assign o_cmd_pop   = (r_state == ST_IDLE) && i_cmd_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign out_last    = r_err || (r_idx == LAST_WORD);

    // one compression round and one schedule step per cycle
    always_comb begin
        s0    = rotr(r_win[1], 7) ^ rotr(r_win[1], 18) ^ (r_win[1] >> 3);
        s1    = rotr(r_win[14], 17) ^ rotr(r_win[14], 19) ^ (r_win[14] >> 10);
        w_new = s1 + r_win[9] + s0 + r_win[0];
        bs1   = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        bs0   = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1    = r_v[7] + bs1 + ch + k_round(r_round) + r_win[0];
        t2    = bs0 + maj;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ret       <= ST_IDLE;
            r_fill      <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= h_init(3'(i));
            end
        end else begin
            // in ST_OUT the output register is handled below
            if (r_out_valid && !i_out_stall && r_state != ST_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        case (i_cmd.kind)
                            CMD_ABSORB: begin
                                r_buf  <= {r_buf[503:0], i_cmd.data};
                                r_fill <= r_fill + 6'd1;
                                if (r_fill == LAST_FILL) begin
                                    r_state <= ST_LOAD;
                                    r_ret   <= ST_IDLE;
                                end
                            end
                            CMD_FIN: begin
                                r_buf  <= {r_buf[503:0], PAD_BYTE};
                                r_fill <= r_fill + 6'd1;
                                r_len  <= i_cmd.bit_len;
                                r_err  <= 1'b0;
                                if (r_fill == LAST_FILL) begin
                                    r_state <= ST_LOAD;
                                    r_ret   <= ST_PAD;
                                end else if (r_fill == PRE_LEN_FILL) begin
                                    r_state <= ST_LEN;
                                end else begin
                                    r_state <= ST_PAD;
                                end
                            end
                            CMD_FIN_ERR: begin
                                r_err   <= 1'b1;
                                r_idx   <= '0;
                                r_state <= ST_OUT;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_PAD: begin
                    r_buf  <= {r_buf[503:0], 8'h00};
                    r_fill <= r_fill + 6'd1;
                    if (r_fill == LAST_FILL) begin
                        r_state <= ST_LOAD;
                        r_ret   <= ST_PAD;
                    end else if (r_fill == PRE_LEN_FILL) begin
                        r_state <= ST_LEN;
                    end
                end
                ST_LEN: begin
                    // bit length goes in big-endian, one byte a cycle
                    r_buf  <= {r_buf[503:0], r_len[63:56]};
                    r_len  <= {r_len[55:0], 8'h00};
                    r_fill <= r_fill + 6'd1;
                    if (r_fill == LAST_FILL) begin
                        r_state <= ST_LOAD;
                        r_ret   <= ST_OUT;
                        r_idx   <= '0;
                    end
                end
                ST_LOAD: begin
                    for (int i = 0; i < 16; i++) begin
                        r_win[i] <= r_buf[511 - 32 * i -: 32];
                    end
                    for (int i = 0; i < 8; i++) begin
                        r_v[i] <= r_chain[i];
                    end
                    r_round <= '0;
                    r_fill  <= '0;
                    r_state <= ST_ROUND;
                end
                ST_ROUND: begin
                    for (int i = 0; i < 15; i++) begin
                        r_win[i] <= r_win[i + 1];
                    end
                    r_win[15] <= w_new;
                    r_v[7]    <= r_v[6];
                    r_v[6]    <= r_v[5];
                    r_v[5]    <= r_v[4];
                    r_v[4]    <= r_v[3] + t1;
                    r_v[3]    <= r_v[2];
                    r_v[2]    <= r_v[1];
                    r_v[1]    <= r_v[0];
                    r_v[0]    <= t1 + t2;
                    r_round   <= r_round + 6'd1;
                    if (r_round == 6'd63) begin
                        r_state <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_chain[i] <= r_chain[i] + r_v[i];
                    end
                    r_state <= r_ret;
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_out_valid        <= 1'b1;
                        r_out.digest_word  <= r_err ? 32'd0 : r_chain[r_idx];
                        r_out.word_index   <= r_err ? 3'd0 : r_idx;
                        r_out.length_error <= r_err;
                        r_out.last         <= out_last;
                        r_idx              <= r_idx + 3'd1;
                        if (out_last) begin
                            for (int i = 0; i < 8; i++) begin
                                r_chain[i] <= h_init(3'(i));
                            end
                            r_fill  <= '0;
                            r_err   <= 1'b0;
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.length_error |-> r_out.last && r_out.word_index == 3'd0)
        else $error("error beat is not a single last beat");

    a_round_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ROUND |-> r_fill == 6'd0)
        else $error("fill count not cleared during compression");

    a_add_after_64: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ADD |-> $past(r_state) == ST_ROUND && $past(r_round) == 6'd63)
        else $error("chain update without 64 rounds");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |=> r_state != ST_ROUND)
        else $error("command taken into a running compression");

endmodule
